/* sv/temp_comp_hysteresis_select_unit_macros.svh */
// Assertion macros shared by the temperature compensation checker
`ifndef TEMP_COMP_HYSTERESIS_SELECT_UNIT_MACROS_SVH
`define TEMP_COMP_HYSTERESIS_SELECT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst
`define TCHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst
`define TCHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked at every edge, reset included
`define TCHS_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* sv/tchs_pkg.sv */
// Types, register indexes and calibration tables for the temperature compensation unit
`timescale 1ns / 1ps

package tchs_pkg;

  typedef logic signed [11:0] tenths_t;

  typedef enum logic [2:0] {
    REG_ADJUST_ENABLE = 3'd0,
    REG_ENTER_LOW     = 3'd1,
    REG_LEAVE_LOW     = 3'd2,
    REG_NORMAL_SET    = 3'd3,
    REG_COLD_SET      = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [15:0] table_b;
    logic [15:0] table_a;
    logic [15:0] empty_voltage;
  } param_set_t;

  localparam int SEG_COUNT = 5;

  localparam tenths_t SEG_BOUND_1 = -12'sd160;
  localparam tenths_t SEG_BOUND_2 = 12'sd1;
  localparam tenths_t SEG_BOUND_3 = 12'sd401;
  localparam tenths_t SEG_BOUND_4 = 12'sd501;

  localparam logic [15:0] SEG_GAIN [SEG_COUNT] =
    '{16'hDFB0, 16'hDF90, 16'hEAC0, 16'hDD50, 16'hDD30};
  localparam logic [15:0] SEG_OFFSET [SEG_COUNT] =
    '{16'h32A5, 16'h3370, 16'h21E2, 16'h2A30, 16'h2A5A};

  // Everything below -160 falls in the coldest segment
  function automatic logic [2:0] seg_index(input tenths_t t);
    logic [2:0] s;
    if (t < SEG_BOUND_1)      s = 3'd0;
    else if (t < SEG_BOUND_2) s = 3'd1;
    else if (t < SEG_BOUND_3) s = 3'd2;
    else if (t < SEG_BOUND_4) s = 3'd3;
    else                      s = 3'd4;
    return s;
  endfunction

  // Scale 1/256 degree to tenths, truncating toward zero
  function automatic tenths_t to_tenths(input logic signed [15:0] raw);
    logic signed [19:0] prod;
    logic signed [19:0] biased;
    prod   = (20'(raw) <<< 3) + (20'(raw) <<< 1);
    biased = prod + (prod[19] ? 20'sd255 : 20'sd0);
    return tenths_t'(biased >>> 8);
  endfunction

endpackage

/* sv/temp_comp_hysteresis_select_unit.sv */
// Temperature compensation: tenths conversion, segment table and hysteresis set select
// Usage:
//   Input channel in_valid/in_ready carries one raw_temperature item (two's
//   complement, 1/256 degree). Output channel out_valid/out_ready carries one
//   result item per input item: temp_tenths, the segment's gain/offset words,
//   the mode after the item, and on a mode switch params_write with the three
//   words of the newly selected parameter set (zero otherwise).
//   The input register loads at the accepting edge; conversion, compare and
//   table logic then fill the result register, which drives out_valid, once
//   it is free. Throughput is one item per cycle while the receiver does not
//   stall; the one-bit mode flag is updated as an item moves into the result
//   register, so items follow back to back.
//   When the receiver stalls, the result register holds and the input
//   register keeps one further item; in_ready drops only when both are full.
//   Registers sit on an APB-style port at byte address 8*index, 64-bit data,
//   pready tied high; write them only while no item is in flight.
//   Synchronous reset clears the pipeline, the mode flag (normal mode) and all
//   registers; no result is shown until an item is accepted after reset.
`timescale 1ns / 1ps

module temp_comp_hysteresis_select_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [15:0] raw_temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [11:0] temp_tenths,
  output logic        [15:0] gain_word,
  output logic        [15:0] offset_word,
  output logic               params_write,
  output logic        [15:0] empty_voltage_word,
  output logic        [15:0] table_word_a,
  output logic        [15:0] table_word_b,
  output logic               cold_mode,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [5:0] paddr,
  input  logic        [63:0] pwdata,
  output logic        [63:0] prdata,
  output logic               pready
);

  // Configuration registers
  logic                 adjust_enable;
  tchs_pkg::tenths_t    enter_low_threshold;
  tchs_pkg::tenths_t    leave_low_threshold;
  tchs_pkg::param_set_t normal_param_set;
  tchs_pkg::param_set_t cold_param_set;

  tchs_pkg::reg_index_t reg_index;
  logic                 cfg_write;

  // Pipeline
  logic                 s1_valid;
  logic signed [15:0]   s1_raw;
  logic                 low_mode_flag;
  logic                 low_mode_flag_next;
  logic                 advance;

  tchs_pkg::tenths_t    t;
  logic [2:0]           seg;
  logic                 wr;
  tchs_pkg::param_set_t set_sel;

  assign pready    = 1'b1;
  assign reg_index = tchs_pkg::reg_index_t'(paddr[5:3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      adjust_enable       <= 1'b0;
      enter_low_threshold <= '0;
      leave_low_threshold <= '0;
      normal_param_set    <= '0;
      cold_param_set      <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        tchs_pkg::REG_ADJUST_ENABLE: adjust_enable       <= pwdata[0];
        tchs_pkg::REG_ENTER_LOW:     enter_low_threshold <= pwdata[11:0];
        tchs_pkg::REG_LEAVE_LOW:     leave_low_threshold <= pwdata[11:0];
        tchs_pkg::REG_NORMAL_SET:    normal_param_set    <= pwdata[47:0];
        tchs_pkg::REG_COLD_SET:      cold_param_set      <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      tchs_pkg::REG_ADJUST_ENABLE: prdata = {63'd0, adjust_enable};
      tchs_pkg::REG_ENTER_LOW:     prdata = {52'd0, enter_low_threshold};
      tchs_pkg::REG_LEAVE_LOW:     prdata = {52'd0, leave_low_threshold};
      tchs_pkg::REG_NORMAL_SET:    prdata = {16'd0, normal_param_set};
      tchs_pkg::REG_COLD_SET:      prdata = {16'd0, cold_param_set};
      default:                     prdata = '0;
    endcase
  end

  // Advance when the result register is empty or being drained
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_raw <= raw_temperature;
    end
  end

  always_comb begin
    t                  = tchs_pkg::to_tenths(s1_raw);
    seg                = tchs_pkg::seg_index(t);
    wr                 = 1'b0;
    set_sel            = '0;
    low_mode_flag_next = low_mode_flag;
    if (adjust_enable) begin
      if (!low_mode_flag && (t <= enter_low_threshold)) begin
        low_mode_flag_next = 1'b1;
        wr                 = 1'b1;
        set_sel            = cold_param_set;
      end else if (low_mode_flag && (t >= leave_low_threshold)) begin
        low_mode_flag_next = 1'b0;
        wr                 = 1'b1;
        set_sel            = normal_param_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      low_mode_flag <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        low_mode_flag <= low_mode_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      temp_tenths        <= t;
      gain_word          <= tchs_pkg::SEG_GAIN[seg];
      offset_word        <= tchs_pkg::SEG_OFFSET[seg];
      params_write       <= wr;
      empty_voltage_word <= set_sel.empty_voltage;
      table_word_a       <= set_sel.table_a;
      table_word_b       <= set_sel.table_b;
      cold_mode          <= low_mode_flag_next;
    end
  end

endmodule

/* sv/tchs_checker.sv */
// Port-level checks for the temperature compensation unit, bound to the top level
`timescale 1ns / 1ps
`include "temp_comp_hysteresis_select_unit_macros.svh"

module tchs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [11:0] temp_tenths,
  input logic        [15:0] gain_word,
  input logic        [15:0] offset_word,
  input logic               params_write,
  input logic        [15:0] empty_voltage_word,
  input logic        [15:0] table_word_a,
  input logic        [15:0] table_word_b,
  input logic               cold_mode
);

  // No result straight after reset
  `TCHS_ASSERT_ALWAYS(a_reset_clears_out, $past(rst), !out_valid, "result after reset")

  // A stalled result holds
  `TCHS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(temp_tenths) && $stable(gain_word) && $stable(cold_mode)
    && $stable(params_write) && $stable(empty_voltage_word), "stalled item changed")

  // Without a mode switch the parameter words are zero
  `TCHS_ASSERT_NOW(a_no_write_zero, out_valid && !params_write,
    empty_voltage_word == 16'h0000 && table_word_a == 16'h0000 && table_word_b == 16'h0000,
    "parameter words without write")

  // Coldest segment carries the coldest gain and offset
  `TCHS_ASSERT_NOW(a_cold_segment, out_valid && (temp_tenths < -12'sd160),
    gain_word == 16'hDFB0 && offset_word == 16'h32A5, "wrong coldest segment words")

endmodule

bind temp_comp_hysteresis_select_unit tchs_checker u_tchs_checker (.*);

/* dv/tchs_calib_checker.sv */
// Calibration checker: predicts each result item of the unit and compares it
`timescale 1ns / 1ps

module tchs_calib_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [15:0]       raw_temperature,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tchs_pkg::tenths_t temp_tenths,
  input  logic [15:0]       gain_word,
  input  logic [15:0]       offset_word,
  input  logic              params_write,
  input  logic [15:0]       empty_voltage_word,
  input  logic [15:0]       table_word_a,
  input  logic [15:0]       table_word_b,
  input  logic              cold_mode,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic  [5:0]       paddr,
  input  logic [63:0]       pwdata,
  input  logic              pready,
  output int                outstanding,
  output int                fail_count
);

  typedef struct {
    tchs_pkg::tenths_t    tenths;
    logic [15:0]          gain;
    logic [15:0]          offset;
    logic                 wr;
    tchs_pkg::param_set_t words;
    logic                 cold;
  } calib_result_t;

  localparam int          SEG_UPPER [4]     = '{-160, 1, 401, 501};
  localparam logic [15:0] GAIN_BY_SEG [5]   = '{16'hDFB0, 16'hDF90, 16'hEAC0, 16'hDD50, 16'hDD30};
  localparam logic [15:0] OFFSET_BY_SEG [5] = '{16'h32A5, 16'h3370, 16'h21E2, 16'h2A30, 16'h2A5A};

  logic                 adjust_on;
  tchs_pkg::tenths_t    enter_thr;
  tchs_pkg::tenths_t    leave_thr;
  tchs_pkg::param_set_t normal_words;
  tchs_pkg::param_set_t cold_words;
  logic                 cold_flag;
  calib_result_t        pending_calib [$];
  calib_result_t        want;
  int                   errors = 0;

  function automatic calib_result_t predict_calib(input logic [15:0] raw);
    calib_result_t r;
    int scaled;
    int tenths;
    int seg;
    int i;
    scaled = $signed(raw) * 10;
    tenths = scaled / 256;
    seg = 4;
    for (i = 3; i >= 0; i--) begin
      if (tenths < SEG_UPPER[i]) seg = i;
    end
    r.tenths = tchs_pkg::tenths_t'(tenths);
    r.gain   = GAIN_BY_SEG[seg];
    r.offset = OFFSET_BY_SEG[seg];
    r.wr     = 1'b0;
    r.words  = '0;
    if (adjust_on) begin
      if (!cold_flag && tenths <= enter_thr) begin
        cold_flag = 1'b1;
        r.wr      = 1'b1;
        r.words   = cold_words;
      end else if (cold_flag && tenths >= leave_thr) begin
        cold_flag = 1'b0;
        r.wr      = 1'b1;
        r.words   = normal_words;
      end
    end
    r.cold = cold_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] exp_val,
                             input logic signed [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_calib.delete();
      adjust_on    = 1'b0;
      enter_thr    = '0;
      leave_thr    = '0;
      normal_words = '0;
      cold_words   = '0;
      cold_flag    = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          tchs_pkg::REG_ADJUST_ENABLE: adjust_on    = pwdata[0];
          tchs_pkg::REG_ENTER_LOW:     enter_thr    = tchs_pkg::tenths_t'(pwdata[11:0]);
          tchs_pkg::REG_LEAVE_LOW:     leave_thr    = tchs_pkg::tenths_t'(pwdata[11:0]);
          tchs_pkg::REG_NORMAL_SET:    normal_words = pwdata[47:0];
          tchs_pkg::REG_COLD_SET:      cold_words   = pwdata[47:0];
          default: ;
        endcase
      end
      // Pop before push: a result can never belong to the item taken on the same edge
      if (out_valid && out_ready) begin
        if (pending_calib.size() == 0) begin
          $error("result item with no expectation waiting");
          errors++;
        end else begin
          want = pending_calib.pop_front();
          check_field("temp_tenths", want.tenths, temp_tenths);
          check_field("gain_word", want.gain, gain_word);
          check_field("offset_word", want.offset, offset_word);
          check_field("params_write", want.wr, params_write);
          check_field("empty_voltage_word", want.words.empty_voltage, empty_voltage_word);
          check_field("table_word_a", want.words.table_a, table_word_a);
          check_field("table_word_b", want.words.table_b, table_word_b);
          check_field("cold_mode", want.cold, cold_mode);
        end
      end
      if (in_valid && in_ready) pending_calib.push_back(predict_calib(raw_temperature));
    end
    outstanding <= pending_calib.size();
    fail_count  <= errors;
  end

endmodule

/* dv/tb_temp_comp_hysteresis_select_unit.sv */
// Testbench top: clock, reset, stimulus, receiver stalls and final verdict
`timescale 1ns / 1ps

module tb_temp_comp_hysteresis_select_unit;

  localparam logic [2:0] SPARE_REG  = 3'd5;
  localparam int         HOLD_SPAN  = 60;
  localparam int         PHASE_ITEMS = 250;
  localparam int         SEG_EDGES [5] = '{-200, -160, 1, 401, 501};

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [15:0]       raw_temperature;
  logic              out_valid;
  logic              out_ready = 1'b0;
  tchs_pkg::tenths_t temp_tenths;
  logic [15:0]       gain_word;
  logic [15:0]       offset_word;
  logic              params_write;
  logic [15:0]       empty_voltage_word;
  logic [15:0]       table_word_a;
  logic [15:0]       table_word_b;
  logic              cold_mode;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic  [5:0]       paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  int   outstanding;
  int   fail_count;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   cur_enter = 0;
  int   cur_leave = 0;
  logic hold_req  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_count = 0;

  temp_comp_hysteresis_select_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .raw_temperature(raw_temperature),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_tenths(temp_tenths), .gain_word(gain_word), .offset_word(offset_word),
    .params_write(params_write), .empty_voltage_word(empty_voltage_word),
    .table_word_a(table_word_a), .table_word_b(table_word_b), .cold_mode(cold_mode),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tchs_calib_checker u_calib_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .raw_temperature(raw_temperature),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_tenths(temp_tenths), .gain_word(gain_word), .offset_word(offset_word),
    .params_write(params_write), .empty_voltage_word(empty_voltage_word),
    .table_word_a(table_word_a), .table_word_b(table_word_b), .cold_mode(cold_mode),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .outstanding(outstanding), .fail_count(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_req toggles
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
      hold_seen  <= hold_req;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_count <= HOLD_SPAN;
      out_ready  <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Smallest-magnitude raw word that converts to the given tenths value
  function automatic logic [15:0] raw_for(input int tenths);
    int m;
    if (tenths >= 0) m = (tenths * 256 + 9) / 10;
    else m = -(((-tenths) * 256 + 9) / 10);
    return m[15:0];
  endfunction

  function automatic int rand_thr();
    return int'($urandom_range(0, 2559)) - 1280;
  endfunction

  function automatic logic [47:0] rand_set();
    return 48'({$urandom, $urandom});
  endfunction

  // Bias towards the thresholds and segment edges so mode switches stay frequent
  function automatic logic [15:0] pick_raw();
    int sel;
    int t;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return 16'($urandom);
    if (sel == 9) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'hFFFF;
        default: return 16'h0000;
      endcase
    end
    if (sel <= 6) t = (sel[0] ? cur_enter : cur_leave) + int'($urandom_range(0, 6)) - 3;
    else t = SEG_EDGES[$urandom_range(0, 4)] + int'($urandom_range(0, 2)) - 1;
    if (t < -1280) t = -1280;
    if (t > 1279) t = 1279;
    return raw_for(t);
  endfunction

  task automatic send_item(input logic [15:0] raw);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    raw_temperature <= raw;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, let every expected item arrive, then allow for the pipeline depth
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Unused upper data bits carry noise; the unit must ignore them
  task automatic load_settings(input logic en, input int enter_thr, input int leave_thr,
                               input logic [47:0] normal_set, input logic [47:0] cold_set);
    logic [63:0] junk;
    wait_idle();
    junk = {$urandom, $urandom};
    write_reg(tchs_pkg::REG_ADJUST_ENABLE, {junk[63:1], en});
    write_reg(tchs_pkg::REG_ENTER_LOW, {junk[63:12], 12'(enter_thr)});
    write_reg(tchs_pkg::REG_LEAVE_LOW, {junk[63:12], 12'(leave_thr)});
    write_reg(tchs_pkg::REG_NORMAL_SET, {junk[63:48], normal_set});
    write_reg(tchs_pkg::REG_COLD_SET, {junk[63:48], cold_set});
    write_reg(SPARE_REG, junk);
    cur_enter = enter_thr;
    cur_leave = leave_thr;
  endtask

  initial begin
    logic [47:0] set_n;
    logic [47:0] set_c;
    int          phase;
    int          n;
    rst             = 1'b1;
    in_valid        = 1'b0;
    raw_temperature = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: switching off, so no item may write parameters
    send_item(16'h8000);
    send_item(16'h7FFF);
    send_item(16'hFFFF);
    send_item(16'h0000);
    send_item(16'hFFE7);
    send_item(raw_for(-201));
    send_item(raw_for(-200));
    send_item(raw_for(-161));
    send_item(raw_for(-160));
    send_item(raw_for(1));
    send_item(raw_for(400));
    send_item(raw_for(401));
    send_item(raw_for(500));
    send_item(raw_for(501));

    // Hysteresis walk: enter at the low threshold, leave at the high one
    set_n = rand_set();
    set_c = rand_set();
    load_settings(1'b1, -100, 50, set_n, set_c);
    send_item(raw_for(-99));
    send_item(raw_for(-100));
    send_item(raw_for(-150));
    send_item(raw_for(49));
    send_item(raw_for(50));
    send_item(raw_for(50));
    send_item(raw_for(-120));
    // Switching off while cold must hold the mode
    load_settings(1'b0, -100, 50, set_n, set_c);
    send_item(raw_for(200));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          load_settings(1'b1, rand_thr(), rand_thr(), rand_set(), rand_set());
        end
        1: begin
          idle_pct  = 54;
          stall_pct = 0;
          load_settings(1'b1, 1279, -1280, 48'hFFFF_FFFF_FFFF, 48'h0);
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
          load_settings(1'b1, -1280, 1279, 48'h0, 48'hFFFF_FFFF_FFFF);
        end
        default: begin
          idle_pct  = 25;
          stall_pct = 25;
          load_settings(1'b1, rand_thr(), rand_thr(), rand_set(), rand_set());
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Long receiver hold-off while items keep coming, to back the unit up
        if (phase == 0 && n == 100) hold_req <= ~hold_req;
        send_item(pick_raw());
      end
    end

    wait_idle();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/tchs_pkg.sv
sv/temp_comp_hysteresis_select_unit.sv
sv/tchs_checker.sv
dv/tchs_calib_checker.sv
dv/tb_temp_comp_hysteresis_select_unit.sv
